// ===== rtl/mppc_pkg.sv =====
package mppc_pkg;

   localparam int NUM_SLOTS            = 32;
   localparam int MAX_PATTERN_LEN      = 16;
   localparam int NUM_SERVICES         = 8;
   localparam int PATTERNS_PER_SERVICE = 4;

   localparam int SLOT_W = 5;
   localparam int POS_W  = 4;
   localparam int BYTE_W = 8;
   localparam int LEN_W  = 5;
   localparam int SVC_W  = 3;
   localparam int RANK_W = 2;

   localparam int REQ_DATA_W = 32;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 24;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      FUNC_PATTERN_BYTE = 2'd0,
      FUNC_SLOT_INFO    = 2'd1,
      FUNC_START        = 2'd2,
      FUNC_DATA         = 2'd3
   } func_type;

   typedef struct packed {
      func_type             func;
      logic [SLOT_W-1:0]    slot;
      logic [POS_W-1:0]     position;
      logic [BYTE_W-1:0]    byte_value;
      logic [LEN_W-1:0]     pattern_length;
      logic [SVC_W-1:0]     service_index;
      logic [RANK_W-1:0]    pattern_rank;
      logic                 slot_enable;
   } cmd_type;

endpackage

// ===== rtl/multi_pattern_prefix_classifier.sv =====
// Prefix classifier for the opening bytes of a connection. Requests carry a
// function code in tuser: pattern byte write, slot info write, stream start or
// data byte; only a data byte gives a response. Requests enter a two-entry
// queue, so up to two more are taken while a response waits, and an execution
// engine drains it. Load and start requests are carried out as the engine takes
// them. A data byte passes through the read of the position-major pattern row
// (one small memory per slot, all read at the current byte count), the
// agreement and count update, and the priority select of the first consistent
// and first complete slot into the response register. The pattern memories are
// not cleared: every byte a stream compares against must be written first.
module multi_pattern_prefix_classifier (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // slot, position, byte_value, pattern_length, service_index, pattern_rank,
   // slot_enable, zero fill
   input  logic [mppc_pkg::REQ_DATA_W-1:0]    req_tdata,
   // func
   input  logic [mppc_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // full_match, hit_service, match_pattern, partial_match, could_service,
   // could_pattern, bytes_seen, zero fill
   output logic [mppc_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import mppc_pkg::*;

   logic    q_valid;
   logic    q_ready;
   cmd_type q_cmd;

   mppc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_cmd      (q_cmd)
   );

   mppc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_cmd      (q_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== rtl/mppc_ram.sv =====
module mppc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/mppc_front.sv =====
module mppc_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [mppc_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [mppc_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                               q_valid,
   input  logic                               q_ready,
   output mppc_pkg::cmd_type                  q_cmd
);
   import mppc_pkg::*;

   cmd_type    queue_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   cmd_type    decoded;
   logic       push, pop;

   // decode and clamp the overlong length
   always_comb begin
      decoded.func           = func_type'(req_tuser);
      decoded.slot           = req_tdata[4:0];
      decoded.position       = req_tdata[8:5];
      decoded.byte_value     = req_tdata[16:9];
      decoded.pattern_length = (req_tdata[21:17] > LEN_W'(MAX_PATTERN_LEN))
                               ? LEN_W'(MAX_PATTERN_LEN) : req_tdata[21:17];
      decoded.service_index  = req_tdata[24:22];
      decoded.pattern_rank   = req_tdata[26:25];
      decoded.slot_enable    = req_tdata[27];
   end

   assign req_tready = (fill_ff != 2'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (fill_ff != 2'd0);
   assign pop        = q_valid && q_ready;
   assign q_cmd      = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// ===== rtl/mppc_back.sv =====
module mppc_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_valid,
   output logic                               q_ready,
   input  mppc_pkg::cmd_type                  q_cmd,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [mppc_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import mppc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_EVAL = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   cmd_type            cur_ff;
   logic [LEN_W-1:0]   len_ff [NUM_SLOTS];
   logic [SVC_W-1:0]   owner_ff [NUM_SLOTS];
   logic [RANK_W-1:0]  rank_ff [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] in_use_ff;
   logic [NUM_SLOTS-1:0] agrees_ff, agrees_in;
   logic [LEN_W-1:0]   count_ff, count_in;
   logic               rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [BYTE_W-1:0]  rd_data [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] wr_en;
   logic               pop, any_longer, rsp_load;
   logic               full, could;
   logic [SVC_W-1:0]   fsvc, csvc;
   logic [RANK_W-1:0]  fpat, cpat;

   assign q_ready = (state_ff == ST_IDLE);
   assign pop     = q_valid && q_ready;

   for (genvar s = 0; s < NUM_SLOTS; s++) begin : g_slot
      assign wr_en[s] = pop && (q_cmd.func == FUNC_PATTERN_BYTE)
                        && (q_cmd.slot == SLOT_W'(s));
      mppc_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_PATTERN_LEN)) u_ram (
         .clock   (clock),
         .wr_en   (wr_en[s]),
         .wr_addr (q_cmd.position),
         .wr_data (q_cmd.byte_value),
         .rd_addr (count_ff[POS_W-1:0]),
         .rd_data (rd_data[s])
      );
   end

   // agreement update and count advance, pattern row arriving from the memories
   always_comb begin
      any_longer = 1'b0;
      agrees_in  = agrees_ff;
      for (int s = 0; s < NUM_SLOTS; s++) begin
         if (in_use_ff[s] && (len_ff[s] > count_ff)) begin
            any_longer = 1'b1;
         end
      end
      if (any_longer) begin
         for (int s = 0; s < NUM_SLOTS; s++) begin
            if ((count_ff < len_ff[s]) && (rd_data[s] != cur_ff.byte_value)) begin
               agrees_in[s] = 1'b0;
            end
         end
      end
      count_in = any_longer ? count_ff + LEN_W'(1) : count_ff;
   end

   // first consistent and first complete slot
   always_comb begin
      full  = 1'b0;
      could = 1'b0;
      fsvc  = '0;
      fpat  = '0;
      csvc  = '0;
      cpat  = '0;
      for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
         if (in_use_ff[s] && agrees_ff[s]) begin
            could = 1'b1;
            csvc  = owner_ff[s];
            cpat  = rank_ff[s];
            if (count_ff >= len_ff[s]) begin
               full = 1'b1;
               fsvc = owner_ff[s];
               fpat = rank_ff[s];
            end
         end
      end
      rsp_data_in = {7'd0, count_ff, cpat, csvc, could, fpat, fsvc, full};
   end

   assign rsp_load = (state_ff == ST_EVAL) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop && (q_cmd.func == FUNC_DATA)) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_use_ff    <= '0;
         agrees_ff    <= '1;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < NUM_SLOTS; s++) begin
            len_ff[s]   <= '0;
            owner_ff[s] <= '0;
            rank_ff[s]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (pop && (q_cmd.func == FUNC_SLOT_INFO)) begin
            len_ff[q_cmd.slot]    <= q_cmd.pattern_length;
            owner_ff[q_cmd.slot]  <= q_cmd.service_index;
            rank_ff[q_cmd.slot]   <= q_cmd.pattern_rank;
            in_use_ff[q_cmd.slot] <= q_cmd.slot_enable;
         end
         if (pop && (q_cmd.func == FUNC_START)) begin
            count_ff  <= '0;
            agrees_ff <= '1;
         end
         if (state_ff == ST_READ) begin
            count_ff  <= count_in;
            agrees_ff <= agrees_in;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= q_cmd;
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
